FILE: rtl/e2q_pkg.sv
// Shared constants, types and helper functions for the Euler-to-quaternion block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Half-angle units are 1/128 degree.
  localparam int TURN_UNITS      = 46080;
  localparam int HALF_TURN_UNITS = 23040;
  localparam int QUARTER_UNITS   = 11520;

  localparam int Z_W        = 26;  // CORDIC angle accumulator, 2^-16 degree
  localparam int Z_SHIFT    = 9;   // half angle to accumulator units
  localparam int XY_W       = 32;  // CORDIC vector
  localparam int CS_SHIFT   = 8;   // vector to cos/sin scaling
  localparam int CS_W       = 26;  // cos, sin and product terms
  localparam int PROD_W     = 2 * CS_W;
  localparam int FRAC_BITS  = 20;
  localparam int COMP_W     = 26;  // unnormalized quaternion components
  localparam int SQ_W       = 48;
  localparam int SUM_W      = 48;
  localparam int LEN_W      = SUM_W / 2;
  localparam int COMB_LAT   = 6;
  localparam int SQRT_LAT   = LEN_W;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd268435456;

  typedef struct packed {
    logic signed [COMP_W-1:0] w;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } quat_comp_t;

  function automatic int red_w(int aw);
    return ((aw > 16) ? aw : 16) + 2;
  endfunction

  function automatic int red_steps(int aw);
    return red_w(aw) - 15;
  endfunction

  function automatic int lane_lat(int aw, int steps);
    return red_steps(aw) + steps + 3;
  endfunction

  function automatic int div_lat(int ow);
    return ow + 3;
  endfunction

  function automatic int total_lat(int aw, int ow, int steps);
    return lane_lat(aw, steps) + COMB_LAT + SQRT_LAT + div_lat(ow);
  endfunction

  // round(atan(2^-i) in degrees * 65536)
  function automatic logic signed [Z_W-1:0] atan_val(int i);
    case (i)
      0:       return 26'sd2949120;
      1:       return 26'sd1740967;
      2:       return 26'sd919879;
      3:       return 26'sd466945;
      4:       return 26'sd234379;
      5:       return 26'sd117304;
      6:       return 26'sd58666;
      7:       return 26'sd29335;
      8:       return 26'sd14668;
      9:       return 26'sd7334;
      10:      return 26'sd3667;
      11:      return 26'sd1833;
      12:      return 26'sd917;
      13:      return 26'sd458;
      14:      return 26'sd229;
      15:      return 26'sd115;
      16:      return 26'sd57;
      17:      return 26'sd29;
      18:      return 26'sd14;
      19:      return 26'sd7;
      20:      return 26'sd4;
      21:      return 26'sd2;
      22:      return 26'sd1;
      default: return '0;
    endcase
  endfunction

  // Fixed-point product with a floor shift by FRAC_BITS.
  function automatic logic signed [CS_W-1:0] fmul(logic signed [CS_W-1:0] a,
                                                  logic signed [CS_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return CS_W'(p >>> FRAC_BITS);
  endfunction

endpackage

FILE: rtl/e2q_if.sv
// Handshake channels of the block: the angle input and the quaternion result.
// Depends on e2q_pkg for default widths.
`timescale 1ns / 1ps

interface e2q_in_if #(
  parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;

  modport source (output valid, pitch_angle, roll_angle, yaw_angle, input ready);
  modport sink   (input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

interface e2q_out_if #(
  parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] quat_w;
  logic signed [OUT_WIDTH-1:0] quat_x;
  logic signed [OUT_WIDTH-1:0] quat_y;
  logic signed [OUT_WIDTH-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

FILE: rtl/euler_to_quaternion.sv
// Euler angles (ZYX) to unit quaternion in signed Q1.(OUT_WIDTH-1).
// Throughput one item per cycle while the output is not stalled, set by the fully
// pipelined CORDIC lanes, square root and divider stages.
// Stalls hold the whole pipeline only while its last stage and the output register
// are both full. Synchronous active-low reset clears the stage valid bits.
`timescale 1ns / 1ps

module euler_to_quaternion #(
  parameter int ANGLE_WIDTH  = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = e2q_pkg::OUT_WIDTH_DEF,
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  e2q_in_if.sink      in_ch,
  e2q_out_if.source   out_ch
);

  localparam int LAT = e2q_pkg::total_lat(ANGLE_WIDTH, OUT_WIDTH, CORDIC_STEPS);

  logic [LAT-1:0] vld_r;
  logic           adv;
  logic           out_valid_r;
  logic           out_valid_nxt;

  assign adv         = !out_valid_r || out_ch.ready || !vld_r[LAT-1];
  assign in_ch.ready = adv;

  logic signed [e2q_pkg::CS_W-1:0] cp, sp, cr, sr, cy, sy;

  e2q_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(adv), .angle(in_ch.pitch_angle), .cos_o(cp), .sin_o(sp)
  );
  e2q_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(adv), .angle(in_ch.roll_angle), .cos_o(cr), .sin_o(sr)
  );
  e2q_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(adv), .angle(in_ch.yaw_angle), .cos_o(cy), .sin_o(sy)
  );

  e2q_pkg::quat_comp_t           comp_c;
  e2q_pkg::quat_comp_t           comp_s;
  logic [e2q_pkg::SUM_W-1:0]     sum;
  logic [e2q_pkg::LEN_W-1:0]     len;

  e2q_combine u_combine (
    .clk(clk), .en(adv), .cp(cp), .sp(sp), .cr(cr), .sr(sr), .cy(cy), .sy(sy),
    .comp_o(comp_c), .sum_o(sum)
  );

  e2q_sqrt u_sqrt (
    .clk(clk), .en(adv), .sum_i(sum), .comp_i(comp_c), .len_o(len), .comp_o(comp_s)
  );

  logic signed [OUT_WIDTH-1:0] qw, qx, qy, qz;
  logic signed [OUT_WIDTH-1:0] qw_r, qx_r, qy_r, qz_r;

  e2q_norm_div #(.OUT_WIDTH(OUT_WIDTH)) u_div_w (
    .clk(clk), .en(adv), .comp(comp_s.w), .len(len), .q_o(qw)
  );
  e2q_norm_div #(.OUT_WIDTH(OUT_WIDTH)) u_div_x (
    .clk(clk), .en(adv), .comp(comp_s.x), .len(len), .q_o(qx)
  );
  e2q_norm_div #(.OUT_WIDTH(OUT_WIDTH)) u_div_y (
    .clk(clk), .en(adv), .comp(comp_s.y), .len(len), .q_o(qy)
  );
  e2q_norm_div #(.OUT_WIDTH(OUT_WIDTH)) u_div_z (
    .clk(clk), .en(adv), .comp(comp_s.z), .len(len), .q_o(qz)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && vld_r[LAT-1]) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        vld_r <= {vld_r[LAT-2:0], in_ch.valid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[LAT-1]) begin
      qw_r <= qw;
      qx_r <= qx;
      qy_r <= qy;
      qz_r <= qz;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.quat_w = qw_r;
  assign out_ch.quat_x = qx_r;
  assign out_ch.quat_y = qy_r;
  assign out_ch.quat_z = qz_r;

endmodule

FILE: rtl/e2q_cordic_lane.sv
// One angle lane: range reduction of the half angle and a pipelined CORDIC
// that gives its cosine and sine. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_cordic_lane #(
  parameter int ANGLE_WIDTH  = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [ANGLE_WIDTH-1:0]     angle,
  output logic signed [e2q_pkg::CS_W-1:0]   cos_o,
  output logic signed [e2q_pkg::CS_W-1:0]   sin_o
);

  localparam int RW   = e2q_pkg::red_w(ANGLE_WIDTH);
  localparam int NRED = e2q_pkg::red_steps(ANGLE_WIDTH);
  localparam int ZW   = e2q_pkg::Z_W;
  localparam int XW   = e2q_pkg::XY_W;
  localparam int CW   = e2q_pkg::CS_W;
  // Whole number of turns that lifts every input to a nonnegative value.
  localparam logic [RW-1:0] OFFSET =
    RW'(((64'd1 << (ANGLE_WIDTH - 1)) + 64'd46079) / 64'd46080 * 64'd46080);
  localparam logic signed [16:0] TURN_S    = 17'(e2q_pkg::TURN_UNITS);
  localparam logic signed [16:0] HALF_S    = 17'(e2q_pkg::HALF_TURN_UNITS);
  localparam logic signed [16:0] QUARTER_S = 17'(e2q_pkg::QUARTER_UNITS);

  logic [RW-1:0]          u_r   [0:NRED];
  logic signed [XW-1:0]   x_r   [0:CORDIC_STEPS];
  logic signed [XW-1:0]   y_r   [0:CORDIC_STEPS];
  logic signed [ZW-1:0]   z_r   [0:CORDIC_STEPS];
  logic                   neg_r [0:CORDIC_STEPS];
  logic signed [CW-1:0]   cos_r;
  logic signed [CW-1:0]   sin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= RW'(angle) + OFFSET;
    end
  end

  // Restoring reduction modulo one turn, one shifted turn per stage.
  for (genvar j = 0; j < NRED; j++) begin : g_red
    localparam logic [RW-1:0] SUB = RW'(64'(e2q_pkg::TURN_UNITS) << (NRED - 1 - j));
    always_ff @(posedge clk) begin
      if (en) begin
        u_r[j+1] <= (u_r[j] >= SUB) ? u_r[j] - SUB : u_r[j];
      end
    end
  end

  // Center the half angle and fold it into [-90, 90] degrees.
  logic signed [16:0] r_c;
  logic signed [16:0] r_f;
  logic               neg_f;

  always_comb begin
    r_c   = $signed({1'b0, u_r[NRED][15:0]});
    if (r_c >= HALF_S) begin
      r_c = r_c - TURN_S;
    end
    r_f   = r_c;
    neg_f = 1'b0;
    if (r_c > QUARTER_S) begin
      r_f   = r_c - HALF_S;
      neg_f = 1'b1;
    end else if (r_c < -QUARTER_S) begin
      r_f   = r_c + HALF_S;
      neg_f = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= e2q_pkg::CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= ZW'(r_f) <<< e2q_pkg::Z_SHIFT;
      neg_r[0] <= neg_f;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = e2q_pkg::atan_val(i);
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
      end
    end
  end

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = x_r[CORDIC_STEPS] >>> e2q_pkg::CS_SHIFT;
  assign ys = y_r[CORDIC_STEPS] >>> e2q_pkg::CS_SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[CORDIC_STEPS] ? CW'(-xs) : CW'(xs);
      sin_r <= neg_r[CORDIC_STEPS] ? CW'(-ys) : CW'(ys);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: rtl/e2q_combine.sv
// Merging stage: combines the three lanes' cosines and sines into the
// unnormalized quaternion and its sum of squares. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_combine (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [e2q_pkg::CS_W-1:0]    cp,
  input  logic signed [e2q_pkg::CS_W-1:0]    sp,
  input  logic signed [e2q_pkg::CS_W-1:0]    cr,
  input  logic signed [e2q_pkg::CS_W-1:0]    sr,
  input  logic signed [e2q_pkg::CS_W-1:0]    cy,
  input  logic signed [e2q_pkg::CS_W-1:0]    sy,
  output e2q_pkg::quat_comp_t                comp_o,
  output logic [e2q_pkg::SUM_W-1:0]          sum_o
);

  localparam int CW = e2q_pkg::CS_W;
  localparam int PW = e2q_pkg::PROD_W;
  localparam int QW = e2q_pkg::SQ_W;

  logic signed [CW-1:0] cycr_r, sysr_r, cysr_r, sycr_r, cp_r, sp_r;
  logic signed [CW-1:0] t_r [0:7];
  e2q_pkg::quat_comp_t  comp_c_r, comp_d_r, comp_e_r, comp_f_r;
  logic [QW-1:0]        sq_r [0:3];
  logic [QW-1:0]        s01_r, s23_r;
  logic [e2q_pkg::SUM_W-1:0] sum_r;
  logic signed [PW-1:0] p_w, p_x, p_y, p_z;

  always_ff @(posedge clk) begin
    if (en) begin
      cycr_r <= e2q_pkg::fmul(cy, cr);
      sysr_r <= e2q_pkg::fmul(sy, sr);
      cysr_r <= e2q_pkg::fmul(cy, sr);
      sycr_r <= e2q_pkg::fmul(sy, cr);
      cp_r   <= cp;
      sp_r   <= sp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= e2q_pkg::fmul(cycr_r, cp_r);
      t_r[1] <= e2q_pkg::fmul(sysr_r, sp_r);
      t_r[2] <= e2q_pkg::fmul(cysr_r, cp_r);
      t_r[3] <= e2q_pkg::fmul(sycr_r, sp_r);
      t_r[4] <= e2q_pkg::fmul(cycr_r, sp_r);
      t_r[5] <= e2q_pkg::fmul(sysr_r, cp_r);
      t_r[6] <= e2q_pkg::fmul(sycr_r, cp_r);
      t_r[7] <= e2q_pkg::fmul(cysr_r, sp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_c_r.w <= t_r[0] + t_r[1];
      comp_c_r.x <= t_r[2] - t_r[3];
      comp_c_r.y <= t_r[4] + t_r[5];
      comp_c_r.z <= t_r[6] - t_r[7];
    end
  end

  assign p_w = PW'(comp_c_r.w) * PW'(comp_c_r.w);
  assign p_x = PW'(comp_c_r.x) * PW'(comp_c_r.x);
  assign p_y = PW'(comp_c_r.y) * PW'(comp_c_r.y);
  assign p_z = PW'(comp_c_r.z) * PW'(comp_c_r.z);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0]  <= QW'(p_w);
      sq_r[1]  <= QW'(p_x);
      sq_r[2]  <= QW'(p_y);
      sq_r[3]  <= QW'(p_z);
      comp_d_r <= comp_c_r;
      s01_r    <= sq_r[0] + sq_r[1];
      s23_r    <= sq_r[2] + sq_r[3];
      comp_e_r <= comp_d_r;
      sum_r    <= e2q_pkg::SUM_W'(s01_r) + e2q_pkg::SUM_W'(s23_r);
      comp_f_r <= comp_e_r;
    end
  end

  assign comp_o = comp_f_r;
  assign sum_o  = sum_r;

endmodule

FILE: rtl/e2q_sqrt.sv
// Pipelined floor square root, one result bit per stage, with the
// quaternion components carried alongside. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [e2q_pkg::SUM_W-1:0]     sum_i,
  input  e2q_pkg::quat_comp_t           comp_i,
  output logic [e2q_pkg::LEN_W-1:0]     len_o,
  output e2q_pkg::quat_comp_t           comp_o
);

  localparam int NW  = e2q_pkg::SUM_W;
  localparam int LW  = e2q_pkg::LEN_W;
  localparam int RMW = LW + 3;

  logic [RMW-1:0]      rem_r  [0:LW-1];
  logic [LW-1:0]       root_r [0:LW-1];
  logic [NW-1:0]       n_r    [0:LW-1];
  e2q_pkg::quat_comp_t comp_r [0:LW-1];

  for (genvar k = 0; k < LW; k++) begin : g_st
    logic [RMW-1:0]      rem_in;
    logic [LW-1:0]       root_in;
    logic [NW-1:0]       n_in;
    e2q_pkg::quat_comp_t comp_in;
    logic [RMW-1:0]      cur;
    logic [RMW-1:0]      trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sum_i;
      assign comp_in = comp_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
      assign comp_in = comp_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign cur   = {rem_in[RMW-3:0], n_in[NW-1-2*k -: 2]};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? cur - trial : cur;
        root_r[k] <= {root_in[LW-2:0], ge};
        n_r[k]    <= n_in;
        comp_r[k] <= comp_in;
      end
    end
  end

  assign len_o  = root_r[LW-1];
  assign comp_o = comp_r[LW-1];

endmodule

FILE: rtl/e2q_norm_div.sv
// One normalization lane: rounded division of a component's magnitude by the
// length, one quotient bit per stage, then sign and saturation. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_norm_div #(
  parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2q_pkg::COMP_W-1:0] comp,
  input  logic [e2q_pkg::LEN_W-1:0]         len,
  output logic signed [OUT_WIDTH-1:0]       q_o
);

  localparam int CW = e2q_pkg::COMP_W;
  localparam int LW = e2q_pkg::LEN_W;
  localparam int QB = OUT_WIDTH + 1;
  localparam int DW = LW + OUT_WIDTH + 1;
  localparam int QW = (QB > CW) ? QB : CW;
  localparam logic [QW-1:0] NMAX = QW'(64'd1 << (OUT_WIDTH - 1));
  localparam logic [QW-1:0] PMAX = NMAX - 1'b1;

  logic [CW-1:0] mag;
  assign mag = comp[CW-1] ? CW'(-comp) : CW'(comp);

  logic [DW-1:0] rem_r  [0:QB];
  logic [LW-1:0] len_r  [0:QB];
  logic [QB-1:0] q_r    [0:QB];
  logic [CW-1:0] mag_r  [0:QB];
  logic          neg_r  [0:QB];
  logic          zero_r [0:QB];
  logic signed [OUT_WIDTH-1:0] res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= (DW'(mag) << (OUT_WIDTH - 1)) + DW'(len >> 1);
      len_r[0]  <= len;
      q_r[0]    <= '0;
      mag_r[0]  <= mag;
      neg_r[0]  <= comp[CW-1];
      zero_r[0] <= (len == '0);
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [DW-1:0] dl;
    logic          ge;
    assign dl = DW'(len_r[j]) << (QB - 1 - j);
    assign ge = (rem_r[j] >= dl);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? rem_r[j] - dl : rem_r[j];
        len_r[j+1]  <= len_r[j];
        q_r[j+1]    <= {q_r[j][QB-2:0], ge};
        mag_r[j+1]  <= mag_r[j];
        neg_r[j+1]  <= neg_r[j];
        zero_r[j+1] <= zero_r[j];
      end
    end
  end

  logic [QW-1:0] qe;
  logic [QW-1:0] qs;

  always_comb begin
    // A zero length passes the magnitude through unscaled.
    qe = zero_r[QB] ? QW'(mag_r[QB]) : QW'(q_r[QB]);
    if (neg_r[QB]) begin
      qs = (qe > NMAX) ? NMAX : qe;
    end else begin
      qs = (qe > PMAX) ? PMAX : qe;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r[QB] ? OUT_WIDTH'(QW'(0) - qs) : OUT_WIDTH'(qs);
    end
  end

  assign q_o = res_r;

endmodule

FILE: rtl/e2q_checker.sv
// Port-level checks for euler_to_quaternion, attached by the bind below.
// Depends on e2q_pkg for the pipeline depth.
`timescale 1ns / 1ps

module e2q_checker #(
  parameter int ANGLE_WIDTH  = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = e2q_pkg::OUT_WIDTH_DEF,
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_WIDTH-1:0] quat_w,
  input logic [OUT_WIDTH-1:0] quat_x,
  input logic [OUT_WIDTH-1:0] quat_y,
  input logic [OUT_WIDTH-1:0] quat_z
);

  // Pipeline stages plus the output register.
  localparam int MAX_ITEMS = e2q_pkg::total_lat(ANGLE_WIDTH, OUT_WIDTH, CORDIC_STEPS) + 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 2);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign cnt_nxt = cnt_r + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
                                && $stable(quat_y) && $stable(quat_z))
    else $error("stalled result item changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result item shown with no item in flight");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("more items in flight than the pipeline holds");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the output side drains");

endmodule

bind euler_to_quaternion e2q_checker #(
  .ANGLE_WIDTH(ANGLE_WIDTH),
  .OUT_WIDTH(OUT_WIDTH),
  .CORDIC_STEPS(CORDIC_STEPS)
) u_e2q_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .quat_w(out_ch.quat_w),
  .quat_x(out_ch.quat_x),
  .quat_y(out_ch.quat_y),
  .quat_z(out_ch.quat_z)
);

FILE: test/tb_top.sv
// Testbench for euler_to_quaternion: drives pitch/roll/yaw items and checks every
// quaternion result against a predictor of the fixed-point CORDIC math.
// Depends on the RTL package, the channel interfaces and the top module.
`timescale 1ns / 1ps

module tb_top;

  localparam int AW = e2q_pkg::ANGLE_WIDTH_DEF;
  localparam int OW = e2q_pkg::OUT_WIDTH_DEF;
  localparam int STEPS = e2q_pkg::CORDIC_STEPS_DEF;
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic signed [OW-1:0] w;
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } quat_t;

  logic clk;
  logic rst_n;
  e2q_in_if #(.ANGLE_WIDTH(AW)) in_ch ();
  e2q_out_if #(.OUT_WIDTH(OW)) out_ch ();

  euler_to_quaternion #(.ANGLE_WIDTH(AW), .OUT_WIDTH(OW), .CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  quat_t expected_quats[$];
  int    error_count = 0;
  int    quiet_cycles = 0;
  bit    idle_on = 0;       // random gaps on both sides
  int    hold_left = 0;     // long receiver hold-off, in cycles
  int    stall_left = 0;

  longint atan_deg16[32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Cosine and sine of the half angle, scaled by 2^20 times the CORDIC gain.
  task automatic half_trig(input logic signed [AW-1:0] ang, output longint c,
                           output longint s);
    longint r, x, y, z, dx, dy;
    bit flip;
    r = longint'(ang) % e2q_pkg::TURN_UNITS;
    flip = 0;
    if (r < 0) r += e2q_pkg::TURN_UNITS;
    if (r >= e2q_pkg::HALF_TURN_UNITS) r -= e2q_pkg::TURN_UNITS;
    if (r > e2q_pkg::QUARTER_UNITS) begin
      r -= e2q_pkg::HALF_TURN_UNITS;
      flip = 1;
    end else if (r < -e2q_pkg::QUARTER_UNITS) begin
      r += e2q_pkg::HALF_TURN_UNITS;
      flip = 1;
    end
    x = longint'(1) << 28;
    y = 0;
    z = r * 512;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg16[i];
      end else begin
        x += dx; y -= dy; z += atan_deg16[i];
      end
    end
    x = x >>> 8;
    y = y >>> 8;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint mul_q20(longint a, longint b);
    return (a * b) >>> 20;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [OW-1:0] normalize(longint comp, longint unsigned len);
    longint unsigned mag, q;
    longint qs;
    mag = (comp < 0) ? longint'(-comp) : comp;
    if (len == 0) q = mag;
    else q = ((mag << (OW - 1)) + len / 2) / len;
    if (comp < 0) begin
      if (q > (64'd1 << (OW - 1))) q = 64'd1 << (OW - 1);
      qs = q;
      return OW'(-qs);
    end
    if (q > (64'd1 << (OW - 1)) - 1) q = (64'd1 << (OW - 1)) - 1;
    return OW'(q);
  endfunction

  task automatic predict_quat(input logic signed [AW-1:0] p, input logic signed [AW-1:0] r,
                              input logic signed [AW-1:0] yw);
    longint cp, sp, cr, sr, cy, sy, w, x, y, z;
    longint unsigned len;
    quat_t q;
    half_trig(p, cp, sp);
    half_trig(r, cr, sr);
    half_trig(yw, cy, sy);
    w = mul_q20(mul_q20(cy, cr), cp) + mul_q20(mul_q20(sy, sr), sp);
    x = mul_q20(mul_q20(cy, sr), cp) - mul_q20(mul_q20(sy, cr), sp);
    y = mul_q20(mul_q20(cy, cr), sp) + mul_q20(mul_q20(sy, sr), cp);
    z = mul_q20(mul_q20(sy, cr), cp) - mul_q20(mul_q20(cy, sr), sp);
    len = floor_sqrt(w * w + x * x + y * y + z * z);
    q.w = normalize(w, len);
    q.x = normalize(x, len);
    q.y = normalize(y, len);
    q.z = normalize(z, len);
    expected_quats.push_back(q);
  endtask

  // Sends one item; returns right after the edge at which it was accepted.
  task automatic send_angles(input logic signed [AW-1:0] p, input logic signed [AW-1:0] r,
                             input logic signed [AW-1:0] yw);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pitch_angle <= p;
    in_ch.roll_angle  <= r;
    in_ch.yaw_angle   <= yw;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    predict_quat(p, r, yw);
  endtask

  function automatic logic signed [AW-1:0] rand_angle();
    case ($urandom_range(0, 3))
      0:       return AW'($urandom_range(0, 1) ? 11520 + $urandom_range(0, 8) - 4
                                               : -11520 + $urandom_range(0, 8) - 4);
      1:       return AW'($urandom_range(0, 1440) - 720);
      default: return AW'($urandom);
    endcase
  endfunction

  task automatic finish_sending();
    in_ch.valid <= 1'b0;
  endtask

  task automatic test_zero_and_extremes();
    logic signed [AW-1:0] vals[6] = '{0, 1, -1, 32767, -32768, 16384};
    foreach (vals[i]) send_angles(vals[i], vals[(i + 1) % 6], vals[(i + 2) % 6]);
    send_angles(32767, 32767, 32767);
    send_angles(-32768, -32768, -32768);
  endtask

  // Angles at and around the points where the half angle is folded by 180 degrees.
  task automatic test_fold_edges();
    logic signed [AW-1:0] vals[8] = '{11520, 11521, -11520, -11521, 23039, -23040,
                                      23040, 5760};
    foreach (vals[i]) send_angles(vals[i], vals[(i + 3) % 8], vals[(i + 5) % 8]);
    send_angles(0, 0, 23040);
    send_angles(0, 23040, 0);
    send_angles(23040, 0, 0);
  endtask

  // With vary_idle set, idling switches on and off in blocks of 150 items;
  // otherwise the current idling setting is kept.
  task automatic test_random(input int n, input bit vary_idle);
    for (int i = 0; i < n; i++) begin
      if (vary_idle) idle_on = ((i / 150) % 3) != 2;
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  // Receiver holds off while items keep coming, so the pipeline fills and stalls.
  task automatic test_backpressure();
    idle_on = 0;
    hold_left = 250;
    for (int i = 0; i < 150; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  // Sender pauses until every result of earlier items has come back.
  task automatic test_drain_pause();
    finish_sending();
    while (expected_quats.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.pitch_angle <= '0;
    in_ch.roll_angle <= '0;
    in_ch.yaw_angle <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_and_extremes();
    test_fold_edges();
    test_random(1000, 1'b1);
    test_backpressure();
    test_drain_pause();
    idle_on = 0;
    test_random(250, 1'b0);
    finish_sending();
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result-side ready: random stall bursts, plus the long hold-off when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Handshake signals are stable at the falling edge, so results are checked there.
  always @(negedge clk) begin
    quat_t exp_q;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_quats.size() == 0) begin
        $error("result with no item outstanding: w=%0d x=%0d y=%0d z=%0d",
               out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z);
        error_count++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_ch.quat_w !== exp_q.w) begin
          $error("quat_w expected %0d actual %0d", exp_q.w, out_ch.quat_w);
          error_count++;
        end
        if (out_ch.quat_x !== exp_q.x) begin
          $error("quat_x expected %0d actual %0d", exp_q.x, out_ch.quat_x);
          error_count++;
        end
        if (out_ch.quat_y !== exp_q.y) begin
          $error("quat_y expected %0d actual %0d", exp_q.y, out_ch.quat_y);
          error_count++;
        end
        if (out_ch.quat_z !== exp_q.z) begin
          $error("quat_z expected %0d actual %0d", exp_q.z, out_ch.quat_z);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
